// ===== rtl/delimited_field_selector_core_macros.svh =====
// Assertion macros for the delimited field selector core.
`ifndef DELIMITED_FIELD_SELECTOR_CORE_MACROS_SVH
`define DELIMITED_FIELD_SELECTOR_CORE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define DFS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define DFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/dfs_pkg.sv =====
// Shared types and constants of the delimited field selector.
`timescale 1ns / 1ps

package dfs_pkg;

  localparam int POS_W      = 16;
  localparam int OFF_W      = 48;
  localparam int NUM_W      = 6;
  localparam int MASK_W     = 16;
  localparam int CNT_W      = 5;
  localparam int SEP_W      = 32;
  localparam int SEP_LEN_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_LINE   = 65536;
  localparam int POS_FIELDS = 16;
  localparam int SEP_MAX    = 4;

  localparam int POS_LIMIT_I = (MAX_LINE - 1 < 65535) ? MAX_LINE - 1 : 65535;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_LIMIT_I[POS_W-1:0];

  localparam int SEP_LIM_I = (SEP_MAX < 4) ? SEP_MAX : 4;
  localparam logic [SEP_LEN_W-1:0] SEP_LIM = SEP_LIM_I[SEP_LEN_W-1:0];

  localparam int POS_SEL_I = (POS_FIELDS < MASK_W) ? POS_FIELDS : MASK_W;
  localparam logic [CNT_W-1:0] POS_SEL = POS_SEL_I[CNT_W-1:0];
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEP_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_MASK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_MASK  = 2'd3;

  typedef struct packed {
    logic                 hit;
    logic [SEP_LEN_W-1:0] len;
  } match_t;

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_ADDR = 3'b010,
    ST_DATA = 3'b100
  } state_t;

endpackage

// ===== rtl/dfs_byte_if.sv =====
// Byte channel: one line byte per transfer.
`timescale 1ns / 1ps

interface dfs_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        end_of_line;
  logic [47:0] line_file_offset;

  modport source (output valid, output data_byte, output end_of_line,
                  output line_file_offset, input ready);
  modport sink (input valid, input data_byte, input end_of_line,
                input line_file_offset, output ready);
endinterface

// ===== rtl/dfs_field_if.sv =====
// Field channel: one selected field per transfer.
`timescale 1ns / 1ps

interface dfs_field_if;
  logic              valid;
  logic              ready;
  logic [15:0]       field_start;
  logic [15:0]       field_length;
  logic signed [5:0] field_number;
  logic [47:0]       field_line_offset;
  logic              last_of_run;

  modport source (output valid, output field_start, output field_length,
                  output field_number, output field_line_offset,
                  output last_of_run, input ready);
  modport sink (input valid, input field_start, input field_length,
                input field_number, input field_line_offset,
                input last_of_run, output ready);
endinterface

// ===== rtl/dfs_match.sv =====
// Separator matcher over the last four bytes of the line.
`timescale 1ns / 1ps

module dfs_match
  import dfs_pkg::*;
(
  input  logic [SEP_W-1:0]     sep_bytes,
  input  logic [SEP_LEN_W-1:0] sep_len,
  input  logic [23:0]          recent_bytes,
  input  logic [7:0]           data_byte,
  input  logic [1:0]           match_blackout,
  input  logic [POS_W-1:0]     byte_position,
  output match_t               m
);

  logic [SEP_LEN_W-1:0] len_eff;
  logic [31:0]          win;

  always_comb begin
    len_eff = (sep_len == '0) ? SEP_LEN_W'(1) : sep_len;
    if (len_eff > SEP_LIM) begin
      len_eff = SEP_LIM;
    end
  end

  assign win = {recent_bytes, data_byte};

  // Separator byte i lines up with window byte len-1-i (newest byte is byte 0).
  always_comb begin
    logic [SEP_LEN_W-1:0] sh;
    m.len = len_eff;
    m.hit = (match_blackout == 2'd0) &&
            (({1'b0, byte_position} + 17'd1) >= 17'(len_eff));
    for (int i = 0; i < 4; i++) begin
      sh = len_eff - SEP_LEN_W'(i) - SEP_LEN_W'(1);
      if (SEP_LEN_W'(i) < len_eff) begin
        if (win[8*sh[1:0] +: 8] != sep_bytes[8*i +: 8]) begin
          m.hit = 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/delimited_field_selector_core.sv =====
// A forward field is presented in the cycle after the byte that closes it.
// Throughput: one byte per cycle while the result side keeps up.
// Line end: each selected backward field takes a ring memory read (ST_ADDR),
// then an output load (ST_DATA); bytes are held off until the last one is loaded.
// Reset: synchronous rst clears line state and restores register defaults;
// the field ring memory is not cleared and only filled entries are read.
`timescale 1ns / 1ps
`include "delimited_field_selector_core_macros.svh"

module delimited_field_selector_core
  import dfs_pkg::*;
#(
  parameter int NEG_FIELDS = 16
)
(
  input  logic                  clk,
  input  logic                  rst,
  dfs_byte_if.sink              bytes,
  dfs_field_if.source           fields,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RW = (NEG_FIELDS > 1) ? $clog2(NEG_FIELDS) : 1;
  localparam int CW = $clog2(NEG_FIELDS + 1);
  localparam logic [CW-1:0] FILL_MAX  = CW'(NEG_FIELDS);
  localparam logic [RW-1:0] HEAD_LAST = RW'(NEG_FIELDS - 1);
  localparam logic [6:0]    DEPTH7    = 7'(NEG_FIELDS);

  // configuration
  logic [SEP_W-1:0]     sep_bytes;
  logic [SEP_LEN_W-1:0] sep_len;
  logic [MASK_W-1:0]    pos_field_mask;
  logic [MASK_W-1:0]    neg_field_mask;

  // line state
  logic [POS_W-1:0] byte_position;
  logic [23:0]      recent_bytes;
  logic [1:0]       match_blackout;
  logic [CNT_W-1:0] forward_count;
  logic [POS_W-1:0] open_field_start;
  logic [CW-1:0]    ring_fill;
  logic [RW-1:0]    ring_head;
  logic [OFF_W-1:0] saved_line_offset;

  // drain control
  state_t           st;
  logic [MASK_W-1:0] drain_mask;
  logic [RW-1:0]    drain_base;
  logic [3:0]       drain_k;

  // field ring: {length, start}
  logic [31:0] ring [NEG_FIELDS];
  logic [31:0] rdata;

  // output register
  logic              ov;
  logic [POS_W-1:0]  o_start;
  logic [POS_W-1:0]  o_len;
  logic [NUM_W-1:0]  o_num;
  logic [OFF_W-1:0]  o_off;
  logic              o_last;

  match_t            m;
  logic              accept;
  logic              eol;
  logic              out_free;
  logic [16:0]       p1;
  logic [POS_W-1:0]  p1_sat;
  logic [POS_W-1:0]  sep_end;
  logic [POS_W-1:0]  close_end;
  logic [POS_W-1:0]  close_len;
  logic              do_close;
  logic              fwd_sel;
  logic [CNT_W-1:0]  cnt_m1;
  logic [RW-1:0]     head_after;
  logic [CW-1:0]     fill_after;
  logic [MASK_W-1:0] dmask;
  logic [3:0]        kidx;
  logic [MASK_W-1:0] mask_rest;
  logic [6:0]        addr_w;
  logic [RW-1:0]     rd_addr;
  logic [OFF_W-1:0]  line_off;
  logic              load_fwd;
  logic              load_bwd;

  dfs_match u_match (
    .sep_bytes      (sep_bytes),
    .sep_len        (sep_len),
    .recent_bytes   (recent_bytes),
    .data_byte      (bytes.data_byte),
    .match_blackout (match_blackout),
    .byte_position  (byte_position),
    .m              (m)
  );

  assign out_free    = !ov || fields.ready;
  assign bytes.ready = (st == ST_RUN) && out_free;
  assign accept      = bytes.valid && bytes.ready;
  assign eol         = bytes.end_of_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_bytes      <= SEP_W'(44);
      sep_len        <= SEP_LEN_W'(1);
      pos_field_mask <= '0;
      neg_field_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEP_BYTES: sep_bytes      <= cfg_data;
        REG_SEP_LEN:   sep_len        <= cfg_data[SEP_LEN_W-1:0];
        REG_POS_MASK:  pos_field_mask <= cfg_data[MASK_W-1:0];
        REG_NEG_MASK:  neg_field_mask <= cfg_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Positions and the field that closes on this byte. A separator and a line
  // end on the same byte never both close a non-empty field.
  always_comb begin
    p1        = {1'b0, byte_position} + 17'd1;
    p1_sat    = (p1 < {1'b0, POS_LIMIT}) ? p1[POS_W-1:0] : POS_LIMIT;
    sep_end   = 16'(p1 - 17'(m.len));
    close_end = m.hit ? sep_end : p1_sat;
    close_len = close_end - open_field_start;
    do_close  = accept && (m.hit || eol) && (forward_count != '0) &&
                (close_end > open_field_start);
    cnt_m1    = forward_count - CNT_W'(1);
    fwd_sel   = (forward_count <= POS_SEL) && pos_field_mask[cnt_m1[3:0]];
    line_off  = (byte_position == '0) ? bytes.line_file_offset : saved_line_offset;
  end

  always_comb begin
    head_after = ring_head;
    fill_after = ring_fill;
    if (do_close) begin
      head_after = (ring_head == HEAD_LAST) ? '0 : ring_head + RW'(1);
      if (ring_fill != FILL_MAX) begin
        fill_after = ring_fill + CW'(1);
      end
    end
    for (int j = 0; j < MASK_W; j++) begin
      dmask[j] = neg_field_mask[j] && (6'(fill_after) > 6'(j));
    end
  end

  // lowest selected backward field still to go
  always_comb begin
    kidx = '0;
    for (int j = MASK_W - 1; j >= 0; j--) begin
      if (drain_mask[j]) begin
        kidx = 4'(j);
      end
    end
    mask_rest = drain_mask & (drain_mask - MASK_W'(1));
    addr_w    = 7'(drain_base) + DEPTH7 - 7'(kidx) - 7'd1;
    if (addr_w >= DEPTH7) begin
      addr_w = addr_w - DEPTH7;
    end
    rd_addr = RW'(addr_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      recent_bytes      <= '0;
      match_blackout    <= '0;
      forward_count     <= '0;
      open_field_start  <= '0;
      ring_fill         <= '0;
      ring_head         <= '0;
      saved_line_offset <= '0;
      drain_mask        <= '0;
      st                <= ST_RUN;
    end else begin
      case (st)
        ST_RUN: begin
          if (accept) begin
            saved_line_offset <= line_off;
            if (eol) begin
              byte_position    <= '0;
              recent_bytes     <= '0;
              match_blackout   <= '0;
              forward_count    <= '0;
              open_field_start <= '0;
              ring_fill        <= '0;
              ring_head        <= '0;
              drain_mask       <= dmask;
              drain_base       <= head_after;
              if (dmask != '0) begin
                st <= ST_ADDR;
              end
            end else begin
              byte_position <= p1_sat;
              recent_bytes  <= {recent_bytes[15:0], bytes.data_byte};
              ring_fill     <= fill_after;
              ring_head     <= head_after;
              if (m.hit) begin
                if (forward_count != CNT_SAT) begin
                  forward_count <= forward_count + CNT_W'(1);
                end
                open_field_start <= p1_sat;
                match_blackout   <= 2'(m.len - SEP_LEN_W'(1));
              end else if (match_blackout != 2'd0) begin
                match_blackout <= match_blackout - 2'd1;
              end
            end
          end
        end
        ST_ADDR: begin
          drain_k <= kidx;
          st      <= ST_DATA;
        end
        ST_DATA: begin
          if (out_free) begin
            drain_mask <= mask_rest;
            st         <= (mask_rest == '0) ? ST_RUN : ST_ADDR;
          end
        end
        default: st <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_close) begin
      ring[ring_head] <= {close_len, open_field_start};
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_ADDR) begin
      rdata <= ring[rd_addr];
    end
  end

  assign load_fwd = do_close && fwd_sel;
  assign load_bwd = (st == ST_DATA) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load_fwd || load_bwd) begin
      ov <= 1'b1;
    end else if (fields.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fwd) begin
      o_start <= open_field_start;
      o_len   <= close_len;
      o_num   <= {1'b0, forward_count};
      o_off   <= line_off;
      o_last  <= !eol || (dmask == '0);
    end else if (load_bwd) begin
      o_start <= rdata[15:0];
      o_len   <= rdata[31:16];
      o_num   <= ~{2'b00, drain_k};  // -(k) with k = drain_k + 1
      o_off   <= saved_line_offset;
      o_last  <= (mask_rest == '0);
    end
  end

  assign fields.valid             = ov;
  assign fields.field_start       = o_start;
  assign fields.field_length      = o_len;
  assign fields.field_number      = o_num;
  assign fields.field_line_offset = o_off;
  assign fields.last_of_run       = o_last;

  `DFS_ASSERT_ALWAYS(a_ring_clear_in_drain, (st == ST_RUN) || (ring_fill == '0 && ring_head == '0), "ring index state not cleared while draining")
  `DFS_ASSERT_ALWAYS(a_fill_bound, ring_fill <= FILL_MAX, "ring fill count exceeds ring depth")
  `DFS_ASSERT_NEXT(a_last_ends_drain, st == ST_DATA && out_free && mask_rest == '0, st == ST_RUN && fields.valid && fields.last_of_run, "final backward field not marked last")

endmodule
